// ----- rtl/arm_mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// arm_mbe_pkg
// Shared types, codes and bank layout helpers for the mode bank and
// exception unit.
// ----------------------------------------------------------------------------
package arm_mbe_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_READ_REG   = 3'd0,
    CMD_WRITE_REG  = 3'd1,
    CMD_MODE       = 3'd2,
    CMD_IRQ        = 3'd3,
    CMD_SWI        = 3'd4,
    CMD_WRITE_CPSR = 3'd5,
    CMD_READ_SPSR  = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_t;

  // condition field codes
  typedef enum logic [3:0] {
    COND_EQ = 4'h0, COND_NE = 4'h1, COND_CS = 4'h2, COND_CC = 4'h3,
    COND_MI = 4'h4, COND_PL = 4'h5, COND_VS = 4'h6, COND_VC = 4'h7,
    COND_HI = 4'h8, COND_LS = 4'h9, COND_GE = 4'hA, COND_LT = 4'hB,
    COND_GT = 4'hC, COND_LE = 4'hD, COND_AL = 4'hE, COND_NV = 4'hF
  } cond_t;

  // mode encodings
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // status word bits
  localparam int BIT_I = 7;
  localparam int BIT_T = 5;

  // visible register indexes
  localparam logic [3:0] IDX_SP = 4'd13;
  localparam logic [3:0] IDX_LR = 4'd14;
  localparam logic [3:0] IDX_PC = 4'd15;

  localparam logic [31:0] IRQ_VECTOR   = 32'h0000_0018;
  localparam logic [31:0] SWI_VECTOR   = 32'h0000_0008;
  localparam logic [31:0] RESET_SP     = 32'h0300_7FE0;
  localparam logic [31:0] RESET_STATUS = 32'h0000_00D3;

  // storage depths
  localparam int NUM_VIS  = 16;
  localparam int NUM_BANK = 22;
  localparam int NUM_SPSR = 5;

  // saved status slots
  localparam logic [2:0] SAVED_FIQ  = 3'd0;
  localparam logic [2:0] SAVED_SVC  = 3'd1;
  localparam logic [2:0] SAVED_ABT  = 3'd2;
  localparam logic [2:0] SAVED_IRQ  = 3'd3;
  localparam logic [2:0] SAVED_UND  = 3'd4;
  localparam logic [2:0] SAVED_NONE = 3'd5;

  // bank slots for sp/lr of each mode
  localparam logic [4:0] SLOT_SVC = 5'd7;
  localparam logic [4:0] SLOT_ABT = 5'd9;
  localparam logic [4:0] SLOT_IRQ = 5'd11;
  localparam logic [4:0] SLOT_UND = 5'd13;
  localparam logic [4:0] SLOT_USR = 5'd20;

  // request held in the input register
  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [4:0]  mode_sel;
    logic [3:0]  cond_code;
  } req_t;

  // result held in the output register
  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] status_word;
    logic        cond_passed;
    logic        irq_taken;
  } res_t;

  // first sp/lr bank slot of a mode, user slots for anything unbanked
  function automatic logic [4:0] sp_lr_slot(input logic [4:0] mode);
    logic [4:0] slot;
    case (mode)
      MODE_SVC: slot = SLOT_SVC;
      MODE_ABT: slot = SLOT_ABT;
      MODE_IRQ: slot = SLOT_IRQ;
      MODE_UND: slot = SLOT_UND;
      default:  slot = SLOT_USR;
    endcase
    return slot;
  endfunction

  // saved status slot of a mode, none for user, system and unknown modes
  function automatic logic [2:0] spsr_slot(input logic [4:0] mode);
    logic [2:0] slot;
    case (mode)
      MODE_FIQ: slot = SAVED_FIQ;
      MODE_SVC: slot = SAVED_SVC;
      MODE_ABT: slot = SAVED_ABT;
      MODE_IRQ: slot = SAVED_IRQ;
      MODE_UND: slot = SAVED_UND;
      default:  slot = SAVED_NONE;
    endcase
    return slot;
  endfunction

endpackage

// ----- rtl/arm_mbe_cond.sv -----
// ----------------------------------------------------------------------------
// arm_mbe_cond
// Condition field test against the N, Z, C, V flags.
// ----------------------------------------------------------------------------
module arm_mbe_cond (
  input  logic [3:0] flags,   // v, c, z, n from the lowest bit up
  input  logic [3:0] cond,
  output logic       passed
);
  import arm_mbe_pkg::*;

  logic n, z, c, v;

  assign n = flags[3];
  assign z = flags[2];
  assign c = flags[1];
  assign v = flags[0];

  // condition decode
  always_comb begin
    case (cond_t'(cond))
      COND_EQ: passed = z;
      COND_NE: passed = !z;
      COND_CS: passed = c;
      COND_CC: passed = !c;
      COND_MI: passed = n;
      COND_PL: passed = !n;
      COND_VS: passed = v;
      COND_VC: passed = !v;
      COND_HI: passed = c && !z;
      COND_LS: passed = !c || z;
      COND_GE: passed = (n == v);
      COND_LT: passed = (n != v);
      COND_GT: passed = !z && (n == v);
      COND_LE: passed = z || (n != v);
      default: passed = 1'b1;
    endcase
  end

endmodule

// ----- rtl/arm_mbe_core.sv -----
// ----------------------------------------------------------------------------
// arm_mbe_core
// Register file, bank store, saved status words and CPSR, with the single
// pass update for one request.
// ----------------------------------------------------------------------------
module arm_mbe_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  arm_mbe_pkg::req_t  req,
  output arm_mbe_pkg::res_t  res
);
  import arm_mbe_pkg::*;

  logic [31:0] vis  [NUM_VIS];
  logic [31:0] bank [NUM_BANK];
  logic [31:0] spsr [NUM_SPSR];
  logic [31:0] cpsr;

  logic [31:0] vis_next  [NUM_VIS];
  logic [31:0] bank_next [NUM_BANK];
  logic [31:0] spsr_next [NUM_SPSR];
  logic [31:0] cpsr_next;

  logic [31:0] rd;
  logic        taken;
  logic        passed;
  logic        do_switch;
  logic        is_irq;
  logic        is_swi;
  logic [4:0]  target;
  logic [4:0]  s_old;
  logic [4:0]  s_new;
  logic [2:0]  sp_idx;

  // condition verdict on the flags before the request
  arm_mbe_cond u_cond (
    .flags  (cpsr[31:28]),
    .cond   (req.cond_code),
    .passed (passed)
  );

  assign s_old  = sp_lr_slot(cpsr[4:0]);
  assign sp_idx = spsr_slot(cpsr[4:0]);

  // command decode, banking and exception entry
  always_comb begin
    vis_next  = vis;
    bank_next = bank;
    spsr_next = spsr;
    cpsr_next = cpsr;
    rd        = '0;
    taken     = 1'b0;
    do_switch = 1'b0;
    is_irq    = 1'b0;
    is_swi    = 1'b0;
    target    = req.mode_sel;

    case (cmd_t'(req.cmd))
      CMD_READ_REG:   rd = vis[req.reg_index];
      CMD_WRITE_REG:  vis_next[req.reg_index] = req.write_data;
      CMD_MODE:       do_switch = 1'b1;
      CMD_IRQ: begin
        if (!cpsr[BIT_I]) begin
          do_switch = 1'b1;
          target    = MODE_IRQ;
          is_irq    = 1'b1;
          taken     = 1'b1;
        end
      end
      CMD_SWI: begin
        do_switch = 1'b1;
        target    = MODE_SVC;
        is_swi    = 1'b1;
      end
      CMD_WRITE_CPSR: cpsr_next = {req.write_data[31:5], cpsr[4:0]};
      CMD_READ_SPSR: begin
        if (sp_idx != SAVED_NONE) begin
          rd = spsr[sp_idx];
        end
      end
      default: ;
    endcase

    s_new = sp_lr_slot(target);

    // bank out the old mode, then bank in the new one
    if (do_switch && (cpsr[4:0] != target)) begin
      if (cpsr[4:0] == MODE_FIQ) begin
        for (int i = 0; i < 7; i++) bank_next[i] = vis[8 + i];
        for (int i = 0; i < 5; i++) vis_next[8 + i] = bank[15 + i];
      end else begin
        bank_next[s_old]        = vis[IDX_SP];
        bank_next[s_old + 5'd1] = vis[IDX_LR];
      end
      if (target == MODE_FIQ) begin
        for (int i = 0; i < 5; i++) bank_next[15 + i] = vis_next[8 + i];
        for (int i = 0; i < 7; i++) vis_next[8 + i] = bank_next[i];
      end else begin
        vis_next[IDX_SP] = bank_next[s_new];
        vis_next[IDX_LR] = bank_next[s_new + 5'd1];
      end
      cpsr_next = {cpsr[31:5], target};
    end

    // exception entry: save status, link, mask irq, leave thumb, vector
    if (is_irq) begin
      spsr_next[SAVED_IRQ] = cpsr;
      vis_next[IDX_LR]     = vis[IDX_PC];
      vis_next[IDX_PC]     = IRQ_VECTOR;
      cpsr_next[BIT_I]     = 1'b1;
      cpsr_next[BIT_T]     = 1'b0;
    end
    if (is_swi) begin
      spsr_next[SAVED_SVC] = cpsr;
      vis_next[IDX_LR]     = vis[IDX_PC] - (cpsr[BIT_T] ? 32'd2 : 32'd4);
      vis_next[IDX_PC]     = SWI_VECTOR;
      cpsr_next[BIT_I]     = 1'b1;
      cpsr_next[BIT_T]     = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VIS; i++) begin
        vis[i] <= (i == int'(IDX_SP)) ? RESET_SP : 32'd0;
      end
      for (int i = 0; i < NUM_BANK; i++) bank[i] <= '0;
      for (int i = 0; i < NUM_SPSR; i++) spsr[i] <= '0;
      cpsr <= RESET_STATUS;
    end else if (fire) begin
      vis  <= vis_next;
      bank <= bank_next;
      spsr <= spsr_next;
      cpsr <= cpsr_next;
    end
  end

  // result of the request in flight
  assign res.read_data   = rd;
  assign res.status_word = cpsr_next;
  assign res.cond_passed = passed;
  assign res.irq_taken   = taken;

endmodule

// ----- rtl/arm_mode_bank_exception_unit_core.sv -----
// ----------------------------------------------------------------------------
// arm_mode_bank_exception_unit_core
// Banked register file and exception entry unit with stream ports.
// ----------------------------------------------------------------------------
// The unit takes one request per clock unless m_tready holds a result back,
// and returns one result per request, in order. A request is captured in an
// input register, applied to the register file, bank store, saved status words
// and CPSR, and its result is loaded into an output register from which it is
// presented on m_tdata. The next request sees all state changes of the one
// before it. Throughput is one request per cycle while m_tready does not stall
// the output; while a result waits for m_tready one more request can still
// enter the input register.
module arm_mode_bank_exception_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd[2:0], reg_index[6:3], write_data[38:7], mode_sel[43:39],
  // cond_code[47:44]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[31:0], status_word[63:32], cond_passed[64], irq_taken[65],
  // zero fill[71:66]
  output logic [71:0] m_tdata
);
  import arm_mbe_pkg::*;

  logic in_valid;
  req_t in_req;
  logic out_valid;
  res_t out_res;
  res_t res;
  logic out_load_ok;
  logic fire;

  // handshake between input and output registers
  assign out_load_ok = !out_valid || m_tready;
  assign fire        = in_valid && out_load_ok;
  assign s_tready    = !in_valid || out_load_ok;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_load_ok) begin
        out_valid <= in_valid;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.cmd        <= s_tdata[2:0];
      in_req.reg_index  <= s_tdata[6:3];
      in_req.write_data <= s_tdata[38:7];
      in_req.mode_sel   <= s_tdata[43:39];
      in_req.cond_code  <= s_tdata[47:44];
    end
  end

  arm_mbe_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (in_req),
    .res  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_res.irq_taken, out_res.cond_passed,
                     out_res.status_word, out_res.read_data};

endmodule

// ----- rtl/arm_mbe_checker.sv -----
// ----------------------------------------------------------------------------
// arm_mbe_checker
// Port level checks for the mode bank and exception unit, bound to the top.
// ----------------------------------------------------------------------------
module arm_mbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);
  import arm_mbe_pkg::*;

  // a waiting request holds until taken
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // with the output side empty the unit always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request refused with output empty");

  // a taken irq leaves the unit in irq mode, masked, in arm state
  a_irq_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[65] |->
      (m_tdata[36:32] == MODE_IRQ) && m_tdata[39] && !m_tdata[37] &&
      (m_tdata[31:0] == 32'd0))
    else $error("irq entry result inconsistent");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result present after reset");

endmodule

bind arm_mode_bank_exception_unit_core arm_mbe_checker u_arm_mbe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/mode_bank_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mode_bank_checker
// Watches both stream channels of the mode bank and exception unit. It keeps
// its own copy of the register file, bank store, saved status words and CPSR,
// predicts the result of every accepted request and compares the results in
// order, field by field.
// ----------------------------------------------------------------------------
module mode_bank_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // cmd[2:0], reg_index[6:3], write_data[38:7], mode_sel[43:39],
  // cond_code[47:44]
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // read_data[31:0], status_word[63:32], cond_passed[64], irq_taken[65],
  // zero fill[71:66]
  input  logic [71:0] m_tdata,
  output int          error_count,
  output int          pending,
  output int          request_count,
  output int          result_count,
  output int          irq_entries
);
  import arm_mbe_pkg::*;

  // shadow copy of the architectural state
  logic [31:0] gpr [NUM_VIS];
  logic [31:0] banked [NUM_BANK];
  logic [31:0] saved_psr [NUM_SPSR];
  logic [31:0] cpsr;

  res_t pending_results [$];

  // bank slot that holds sp of a mode, lr sits right above it
  function automatic int sp_home(input logic [4:0] mode);
    case (mode)
      MODE_SVC: return SLOT_SVC;
      MODE_ABT: return SLOT_ABT;
      MODE_IRQ: return SLOT_IRQ;
      MODE_UND: return SLOT_UND;
      default:  return SLOT_USR;
    endcase
  endfunction

  // saved status index of a mode
  function automatic int psr_home(input logic [4:0] mode);
    case (mode)
      MODE_FIQ: return SAVED_FIQ;
      MODE_SVC: return SAVED_SVC;
      MODE_ABT: return SAVED_ABT;
      MODE_IRQ: return SAVED_IRQ;
      MODE_UND: return SAVED_UND;
      default:  return SAVED_NONE;
    endcase
  endfunction

  // condition field against the n, z, c, v flags
  function automatic logic cond_met(input logic [31:0] psr, input cond_t cc);
    logic n, z, c, v;
    n = psr[31];
    z = psr[30];
    c = psr[29];
    v = psr[28];
    case (cc)
      COND_EQ: return z;
      COND_NE: return !z;
      COND_CS: return c;
      COND_CC: return !c;
      COND_MI: return n;
      COND_PL: return !n;
      COND_VS: return v;
      COND_VC: return !v;
      COND_HI: return c && !z;
      COND_LS: return !c || z;
      COND_GE: return n == v;
      COND_LT: return n != v;
      COND_GT: return !z && (n == v);
      COND_LE: return z || (n != v);
      default: return 1'b1;
    endcase
  endfunction

  // swap banked registers out for the old mode and in for the new one
  task automatic bank_switch(input logic [4:0] target);
    logic [4:0] cur;
    int base;
    cur = cpsr[4:0];
    if (cur != target) begin
      if (cur == MODE_FIQ) begin
        for (int i = 0; i < 7; i++) banked[i] = gpr[8 + i];
        for (int i = 0; i < 5; i++) gpr[8 + i] = banked[15 + i];
      end else begin
        base = sp_home(cur);
        banked[base] = gpr[IDX_SP];
        banked[base + 1] = gpr[IDX_LR];
      end
      if (target == MODE_FIQ) begin
        for (int i = 0; i < 5; i++) banked[15 + i] = gpr[8 + i];
        for (int i = 0; i < 7; i++) gpr[8 + i] = banked[i];
      end else begin
        base = sp_home(target);
        gpr[IDX_SP] = banked[base];
        gpr[IDX_LR] = banked[base + 1];
      end
      cpsr[4:0] = target;
    end
  endtask

  // apply one request to the shadow state and form its result
  task automatic apply_command(input logic [47:0] d, output res_t r);
    cmd_t op;
    logic [3:0] idx;
    logic [31:0] wd;
    logic [4:0] md;
    logic [31:0] prior;
    int s;
    op = cmd_t'(d[2:0]);
    idx = d[6:3];
    wd = d[38:7];
    md = d[43:39];
    prior = cpsr;
    r = '0;
    r.cond_passed = cond_met(prior, cond_t'(d[47:44]));
    case (op)
      CMD_READ_REG:  r.read_data = gpr[idx];
      CMD_WRITE_REG: gpr[idx] = wd;
      CMD_MODE:      bank_switch(md);
      CMD_IRQ: begin
        // masked when the i bit is set
        if (!prior[BIT_I]) begin
          bank_switch(MODE_IRQ);
          saved_psr[SAVED_IRQ] = prior;
          gpr[IDX_LR] = gpr[IDX_PC];
          cpsr[BIT_I] = 1'b1;
          cpsr[BIT_T] = 1'b0;
          gpr[IDX_PC] = IRQ_VECTOR;
          r.irq_taken = 1'b1;
        end
      end
      CMD_SWI: begin
        bank_switch(MODE_SVC);
        saved_psr[SAVED_SVC] = prior;
        gpr[IDX_LR] = gpr[IDX_PC] - (prior[BIT_T] ? 32'd2 : 32'd4);
        cpsr[BIT_I] = 1'b1;
        cpsr[BIT_T] = 1'b0;
        gpr[IDX_PC] = SWI_VECTOR;
      end
      CMD_WRITE_CPSR: cpsr = {wd[31:5], cpsr[4:0]};
      CMD_READ_SPSR: begin
        s = psr_home(cpsr[4:0]);
        if (s != SAVED_NONE) r.read_data = saved_psr[s];
      end
      default: ;
    endcase
    r.status_word = cpsr;
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      error_count++;
    end
  endtask

  // track requests and results at each rising edge
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < NUM_VIS; i++) gpr[i] = '0;
      for (int i = 0; i < NUM_BANK; i++) banked[i] = '0;
      for (int i = 0; i < NUM_SPSR; i++) saved_psr[i] = '0;
      gpr[IDX_SP] = RESET_SP;
      cpsr = RESET_STATUS;
      pending_results.delete();
      error_count = 0;
      request_count = 0;
      result_count = 0;
      irq_entries = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_command(s_tdata, want);
        pending_results.push_back(want);
        request_count++;
        if (want.irq_taken) irq_entries++;
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual %h",
                   $time, m_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", want.read_data, m_tdata[31:0]);
          check_field("status_word", want.status_word, m_tdata[63:32]);
          check_field("cond_passed", 32'(want.cond_passed), 32'(m_tdata[64]));
          check_field("irq_taken", 32'(want.irq_taken), 32'(m_tdata[65]));
          check_field("zero fill", 32'd0, 32'(m_tdata[71:66]));
          result_count++;
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the mode bank and exception unit with random gaps on
// both sides: a directed opening over modes, exceptions and edge values, then
// several hundred random requests. A checker beside the unit scores results.
// ----------------------------------------------------------------------------
module tb_top;
  import arm_mbe_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [47:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;

  int error_count;
  int pending;
  int request_count;
  int result_count;
  int irq_entries;
  bit steady = 1'b0;

  always #5 clk = ~clk;

  arm_mode_bank_exception_unit_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mode_bank_checker monitor (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .error_count   (error_count),
    .pending       (pending),
    .request_count (request_count),
    .result_count  (result_count),
    .irq_entries   (irq_entries)
  );

  // send one request after a random gap, hold it until taken
  task automatic issue(input cmd_t op, input logic [3:0] idx, input logic [31:0] wd,
                       input logic [4:0] md, input cond_t cc);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tdata = {cc, md, wd, idx, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // result side: random stall before each result
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 17);
      repeat (stall) begin
        @(negedge clk);
        m_tready = 1'b0;
      end
      @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // stimulus and verdict
  initial begin
    int pick;
    cmd_t op;
    logic [4:0] md;
    logic [31:0] wd;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed opening: reset values, exception entries, bank swaps
    issue(CMD_READ_REG, IDX_SP, 32'h0, 5'h00, COND_EQ);
    issue(CMD_WRITE_REG, IDX_PC, 32'hFFFF_FFFF, 5'h1F, COND_NE);
    issue(CMD_WRITE_REG, 4'd0, 32'h0, 5'h00, COND_CS);
    issue(CMD_IRQ, 4'd0, 32'h0, 5'h00, COND_CC);          // masked after reset
    issue(CMD_SWI, 4'd0, 32'h0, 5'h00, COND_MI);          // already in svc, arm state
    issue(CMD_READ_SPSR, 4'd0, 32'h0, 5'h00, COND_PL);
    issue(CMD_WRITE_CPSR, 4'd0, 32'hF000_0020, 5'h00, COND_VS); // flags, thumb, i clear
    issue(CMD_SWI, 4'd0, 32'h0, 5'h00, COND_VC);          // thumb return offset
    issue(CMD_WRITE_CPSR, 4'd0, 32'h5000_0000, 5'h00, COND_HI);
    issue(CMD_MODE, 4'd0, 32'h0, MODE_FIQ, COND_LS);
    issue(CMD_WRITE_REG, 4'd8, 32'hA5A5_5A5A, 5'h00, COND_GE);
    issue(CMD_WRITE_REG, IDX_LR, 32'h8000_0001, 5'h00, COND_LT);
    issue(CMD_MODE, 4'd0, 32'h0, MODE_FIQ, COND_GT);      // same mode, no swap
    issue(CMD_READ_SPSR, 4'd0, 32'h0, 5'h00, COND_LE);
    issue(CMD_MODE, 4'd0, 32'h0, 5'h00, COND_AL);         // unknown mode
    issue(CMD_READ_SPSR, 4'd0, 32'h0, 5'h00, COND_NV);
    issue(CMD_IRQ, 4'd0, 32'h0, 5'h00, COND_EQ);          // unmasked, taken
    issue(CMD_READ_REG, IDX_LR, 32'h0, 5'h00, COND_NE);
    issue(CMD_READ_SPSR, 4'd0, 32'h0, 5'h00, COND_GT);
    issue(CMD_MODE, 4'd0, 32'h0, MODE_USR, COND_LE);
    issue(CMD_MODE, 4'd0, 32'h0, MODE_ABT, COND_HI);
    issue(CMD_MODE, 4'd0, 32'h0, MODE_UND, COND_LS);
    issue(CMD_MODE, 4'd0, 32'h0, MODE_SYS, COND_GE);
    issue(CMD_NONE, 4'd0, 32'h0, 5'h00, COND_LT);
    issue(CMD_READ_REG, 4'd8, 32'h0, 5'h00, COND_AL);

    // random phases, the third one runs without gaps on either side
    for (int phase = 0; phase < 4; phase++) begin
      steady = (phase == 2);
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 18)      op = CMD_READ_REG;
        else if (pick < 34) op = CMD_WRITE_REG;
        else if (pick < 54) op = CMD_MODE;
        else if (pick < 66) op = CMD_IRQ;
        else if (pick < 76) op = CMD_SWI;
        else if (pick < 86) op = CMD_WRITE_CPSR;
        else if (pick < 96) op = CMD_READ_SPSR;
        else                op = CMD_NONE;
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 6))
            0:       md = MODE_USR;
            1:       md = MODE_FIQ;
            2:       md = MODE_IRQ;
            3:       md = MODE_SVC;
            4:       md = MODE_ABT;
            5:       md = MODE_UND;
            default: md = MODE_SYS;
          endcase
        end else begin
          md = 5'($urandom);
        end
        case ($urandom_range(0, 7))
          0:       wd = '0;
          1:       wd = '1;
          default: wd = $urandom;
        endcase
        issue(op, 4'($urandom), wd, md, cond_t'($urandom_range(0, 15)));
      end
      // after the first phase let every result drain before going on
      if (phase == 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending == 0);
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    $display("run covered %0d requests over all commands, modes and condition codes",
             request_count);
    $display("%0d results checked in order, %0d irq entries taken", result_count,
             irq_entries);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
